// ===== hw/rtl/imusfp_pkg.sv =====
`default_nettype none

package imusfp_pkg;

  localparam logic [7:0] HDR_BYTE   = 8'h55;
  localparam logic [7:0] TYPE_ACCEL = 8'h51;
  localparam logic [7:0] TYPE_RATE  = 8'h52;
  localparam logic [7:0] TYPE_ANGLE = 8'h53;
  localparam logic [7:0] TYPE_QUAT  = 8'h59;

  localparam logic [3:0] CNT_WAIT   = 4'd0;
  localparam logic [3:0] CNT_TYPE   = 4'd1;
  localparam logic [3:0] CNT_PAY0   = 4'd2;
  localparam logic [3:0] CNT_CHECK  = 4'd10;

  localparam int unsigned MARK_ACCEL = 0;
  localparam int unsigned MARK_RATE  = 1;
  localparam int unsigned MARK_ANGLE = 2;
  localparam int unsigned MARK_QUAT  = 3;
  localparam logic [3:0]  MARKS_ALL  = 4'hF;

  localparam logic KIND_SAMPLE = 1'b0;
  localparam logic KIND_ERROR  = 1'b1;

  typedef struct packed {
    logic             done;
    logic             sum_ok;
    logic [7:0]       ftype;
    logic [3:0][15:0] words;
  } frame_evt_t;

  typedef struct packed {
    logic             kind;
    logic [2:0][15:0] accel;
    logic [2:0][15:0] rate;
    logic [3:0][15:0] quat;
    logic [31:0]      sample_number;
  } result_t;

  function automatic logic type_known(input logic [7:0] t);
    type_known = (t == TYPE_ACCEL) || (t == TYPE_RATE) ||
                 (t == TYPE_ANGLE) || (t == TYPE_QUAT);
  endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/imusfp_frame.sv =====
`default_nettype none

module imusfp_frame
  import imusfp_pkg::*;
(
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       en_i,
  input  wire logic [7:0] byte_i,
  output frame_evt_t      evt_o
);

  logic [3:0]      cnt_q, cnt_d;
  logic [7:0]      sum_q, sum_d;
  logic [7:0]      type_q;
  logic [7:0][7:0] pay_q;
  logic [3:0]      pay_off;
  logic [2:0]      pay_idx;

  assign pay_off = cnt_q - CNT_PAY0;
  assign pay_idx = pay_off[2:0];

  always_comb begin
    cnt_d = cnt_q;
    sum_d = sum_q;
    if (cnt_q == CNT_WAIT) begin
      if (byte_i == HDR_BYTE) begin
        cnt_d = CNT_TYPE;
        sum_d = byte_i;
      end
    end else if (cnt_q == CNT_CHECK) begin
      cnt_d = CNT_WAIT;
    end else begin
      cnt_d = cnt_q + 4'd1;
      sum_d = sum_q + byte_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= CNT_WAIT;
      sum_q <= '0;
    end else if (en_i) begin
      cnt_q <= cnt_d;
      sum_q <= sum_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i && cnt_q == CNT_TYPE) begin
      type_q <= byte_i;
    end
    if (en_i && cnt_q >= CNT_PAY0 && cnt_q < CNT_CHECK) begin
      pay_q[pay_idx] <= byte_i;
    end
  end

  assign evt_o.done   = en_i && (cnt_q == CNT_CHECK) && type_known(type_q);
  assign evt_o.sum_ok = (sum_q == byte_i);
  assign evt_o.ftype  = type_q;
  assign evt_o.words  = pay_q;

  assert property (@(posedge clk_i) disable iff (!rst_ni) cnt_q <= CNT_CHECK)
    else $error("frame byte count out of range");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (en_i && cnt_q == CNT_WAIT && byte_i != HDR_BYTE) |=> cnt_q == CNT_WAIT)
    else $error("non-header byte opened a frame");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    evt_o.done |-> (en_i && cnt_q == CNT_CHECK))
    else $error("frame event outside the checksum byte");

endmodule

`default_nettype wire

// ===== hw/rtl/imusfp_store.sv =====
`default_nettype none

module imusfp_store
  import imusfp_pkg::*;
(
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  frame_evt_t      evt_i,
  output logic            res_vld_o,
  output result_t         res_o
);

  logic [2:0][15:0] accel_q, accel_d;
  logic [2:0][15:0] rate_q, rate_d;
  logic [3:0][15:0] quat_q, quat_d;
  logic [3:0]       marks_q, marks_d;
  logic [31:0]      count_q, count_d;
  logic [3:0]       marks_quat;

  assign marks_quat = marks_q | (4'b1 << MARK_QUAT);

  always_comb begin
    accel_d   = accel_q;
    rate_d    = rate_q;
    quat_d    = quat_q;
    marks_d   = marks_q;
    count_d   = count_q;
    res_vld_o = 1'b0;
    res_o     = '0;
    if (evt_i.done) begin
      if (!evt_i.sum_ok) begin
        res_vld_o  = 1'b1;
        res_o.kind = KIND_ERROR;
      end else begin
        unique case (evt_i.ftype)
          TYPE_ACCEL: begin
            accel_d             = evt_i.words[2:0];
            marks_d[MARK_ACCEL] = 1'b1;
          end
          TYPE_RATE: begin
            rate_d             = evt_i.words[2:0];
            marks_d[MARK_RATE] = 1'b1;
          end
          TYPE_ANGLE: begin
            marks_d[MARK_ANGLE] = 1'b1;
          end
          TYPE_QUAT: begin
            quat_d = evt_i.words;
            if (marks_quat == MARKS_ALL) begin
              marks_d             = '0;
              count_d             = count_q + 32'd1;
              res_vld_o           = 1'b1;
              res_o.kind          = KIND_SAMPLE;
              res_o.accel         = accel_q;
              res_o.rate          = rate_q;
              res_o.quat          = evt_i.words;
              res_o.sample_number = count_d;
            end else begin
              marks_d = marks_quat;
            end
          end
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      accel_q <= '0;
      rate_q  <= '0;
      quat_q  <= '0;
      marks_q <= '0;
      count_q <= '0;
    end else begin
      accel_q <= accel_d;
      rate_q  <= rate_d;
      quat_q  <= quat_d;
      marks_q <= marks_d;
      count_q <= count_d;
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (evt_i.done && !evt_i.sum_ok) |=> $stable(marks_q) && $stable(count_q))
    else $error("checksum failure changed sample state");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_vld_o && res_o.kind == KIND_SAMPLE)
      |=> marks_q == '0 && count_q == $past(count_q) + 32'd1)
    else $error("sample emit did not clear marks or advance count");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_vld_o && res_o.kind == KIND_ERROR) |-> res_o.sample_number == '0)
    else $error("error result carries a sample number");

endmodule

`default_nettype wire

// ===== hw/rtl/imu_serial_frame_parser_unit.sv =====
// IMU serial frame parser. Feed one received byte per item; frames open on
// header 0x55 and run 11 bytes ending in an additive checksum. A result leaves
// only for a completing quaternion frame (sample with all four frame types
// seen) or for a checksum failure on a known type. One byte is accepted every
// cycle while the result side keeps up. An accepted byte is parsed out of the
// input register, and a result is written into the result register when that
// register can advance and is presented from there.
// A stalled result holds back new bytes only while the result register is
// still occupied.
`default_nettype none

module imu_serial_frame_parser_unit
  import imusfp_pkg::*;
(
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output logic                    in_stall_o,
  input  wire logic [7:0]         rx_byte_i,
  output logic                    out_valid_o,
  input  wire logic               out_stall_i,
  output logic                    kind_o,
  output logic signed [15:0]      accel_x_o,
  output logic signed [15:0]      accel_y_o,
  output logic signed [15:0]      accel_z_o,
  output logic signed [15:0]      rate_x_o,
  output logic signed [15:0]      rate_y_o,
  output logic signed [15:0]      rate_z_o,
  output logic signed [15:0]      quat_x_o,
  output logic signed [15:0]      quat_y_o,
  output logic signed [15:0]      quat_z_o,
  output logic signed [15:0]      quat_w_o,
  output logic [31:0]             sample_number_o
);

  logic       in_vld_q;
  logic [7:0] in_byte_q;
  logic       advance;
  logic       fire;
  frame_evt_t evt;
  logic       res_vld;
  result_t    res;
  logic       out_vld_q;
  result_t    out_q;

  assign advance    = !out_vld_q || !out_stall_i;
  assign fire       = in_vld_q && advance;
  assign in_stall_o = in_vld_q && !advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (!in_stall_o) begin
      in_vld_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) begin
      in_byte_q <= rx_byte_i;
    end
  end

  imusfp_frame u_frame (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (fire),
    .byte_i (in_byte_q),
    .evt_o  (evt)
  );

  imusfp_store u_store (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .evt_i     (evt),
    .res_vld_o (res_vld),
    .res_o     (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (advance) begin
      out_vld_q <= res_vld;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && res_vld) begin
      out_q <= res;
    end
  end

  assign out_valid_o     = out_vld_q;
  assign kind_o          = out_q.kind;
  assign accel_x_o       = $signed(out_q.accel[0]);
  assign accel_y_o       = $signed(out_q.accel[1]);
  assign accel_z_o       = $signed(out_q.accel[2]);
  assign rate_x_o        = $signed(out_q.rate[0]);
  assign rate_y_o        = $signed(out_q.rate[1]);
  assign rate_z_o        = $signed(out_q.rate[2]);
  assign quat_x_o        = $signed(out_q.quat[0]);
  assign quat_y_o        = $signed(out_q.quat[1]);
  assign quat_z_o        = $signed(out_q.quat[2]);
  assign quat_w_o        = $signed(out_q.quat[3]);
  assign sample_number_o = out_q.sample_number;

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_vld |-> fire)
    else $error("result produced without a byte in process");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |-> !fire)
    else $error("byte processed while result register blocked");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && kind_o == KIND_SAMPLE) |-> sample_number_o != '0)
    else $error("sample result without a sample number");

endmodule

`default_nettype wire

// ===== verif/tb_imu_serial_frame_parser_unit.sv =====
`timescale 1ns / 100ps

module tb_imu_serial_frame_parser_unit;
  import imusfp_pkg::*;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               in_valid_i = 1'b0;
  logic               in_stall_o;
  logic [7:0]         rx_byte_i = '0;
  logic               out_valid_o;
  logic               out_stall_i = 1'b0;
  logic               kind_o;
  logic signed [15:0] accel_x_o, accel_y_o, accel_z_o;
  logic signed [15:0] rate_x_o, rate_y_o, rate_z_o;
  logic signed [15:0] quat_x_o, quat_y_o, quat_z_o, quat_w_o;
  logic [31:0]        sample_number_o;

  imu_serial_frame_parser_unit dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .rx_byte_i       (rx_byte_i),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .kind_o          (kind_o),
    .accel_x_o       (accel_x_o),
    .accel_y_o       (accel_y_o),
    .accel_z_o       (accel_z_o),
    .rate_x_o        (rate_x_o),
    .rate_y_o        (rate_y_o),
    .rate_z_o        (rate_z_o),
    .quat_x_o        (quat_x_o),
    .quat_y_o        (quat_y_o),
    .quat_z_o        (quat_z_o),
    .quat_w_o        (quat_w_o),
    .sample_number_o (sample_number_o)
  );

  always #5 clk_i = ~clk_i;

  logic [7:0]  rx_stream[$];
  result_t     parsed_results[$];
  int unsigned sender_idle = 0;
  int unsigned receiver_stall = 0;
  int unsigned mismatches = 0;
  int unsigned bytes_queued;

  // parser state mirrored in the testbench
  logic [3:0]  frame_pos = CNT_WAIT;
  logic [7:0]  frame_sum = '0;
  logic [7:0]  frame_code = '0;
  logic [7:0]  body_bytes[8];
  logic [15:0] accel_words[3] = '{default: '0};
  logic [15:0] rate_words[3] = '{default: '0};
  logic [15:0] quat_words[4] = '{default: '0};
  logic [3:0]  seen_marks = '0;
  logic [31:0] samples_sent = '0;

  function automatic logic [15:0] body_word(input int k);
    return {body_bytes[2 * k + 1], body_bytes[2 * k]};
  endfunction

  function automatic bit is_known(input logic [7:0] t);
    return t == TYPE_ACCEL || t == TYPE_RATE || t == TYPE_ANGLE || t == TYPE_QUAT;
  endfunction

  function automatic void parse_byte(input logic [7:0] b);
    result_t r;
    r = '0;
    if (frame_pos == CNT_WAIT) begin
      if (b == HDR_BYTE) begin
        frame_sum = b;
        frame_pos = CNT_TYPE;
      end
    end else if (frame_pos == CNT_TYPE) begin
      frame_code = b;
      frame_sum = frame_sum + b;
      frame_pos = CNT_PAY0;
    end else if (frame_pos < CNT_CHECK) begin
      body_bytes[frame_pos - CNT_PAY0] = b;
      frame_sum = frame_sum + b;
      frame_pos = frame_pos + 4'd1;
    end else begin
      frame_pos = CNT_WAIT;
      if (is_known(frame_code)) begin
        if (frame_sum != b) begin
          r.kind = KIND_ERROR;
          parsed_results.insert(parsed_results.size(), r);
        end else if (frame_code == TYPE_ACCEL) begin
          for (int k = 0; k < 3; k++) accel_words[k] = body_word(k);
          seen_marks[MARK_ACCEL] = 1'b1;
        end else if (frame_code == TYPE_RATE) begin
          for (int k = 0; k < 3; k++) rate_words[k] = body_word(k);
          seen_marks[MARK_RATE] = 1'b1;
        end else if (frame_code == TYPE_ANGLE) begin
          seen_marks[MARK_ANGLE] = 1'b1;
        end else begin
          for (int k = 0; k < 4; k++) quat_words[k] = body_word(k);
          seen_marks[MARK_QUAT] = 1'b1;
          if (seen_marks == MARKS_ALL) begin
            samples_sent = samples_sent + 32'd1;
            seen_marks = '0;
            r.kind = KIND_SAMPLE;
            for (int k = 0; k < 3; k++) begin
              r.accel[k] = accel_words[k];
              r.rate[k] = rate_words[k];
            end
            for (int k = 0; k < 4; k++) r.quat[k] = quat_words[k];
            r.sample_number = samples_sent;
            parsed_results.insert(parsed_results.size(), r);
          end
        end
      end
    end
  endfunction

  task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
    $display("mismatch %s at %0t: got %h, expected %h", what, $time, got, want);
    mismatches++;
  endtask

  task automatic check_result();
    result_t got;
    result_t want;
    got.kind = kind_o;
    got.accel = {accel_z_o, accel_y_o, accel_x_o};
    got.rate = {rate_z_o, rate_y_o, rate_x_o};
    got.quat = {quat_w_o, quat_z_o, quat_y_o, quat_x_o};
    got.sample_number = sample_number_o;
    if (parsed_results.size() == 0) begin
      report("unexpected result, kind", got.kind, '0);
    end else begin
      want = parsed_results.pop_front();
      if (got.kind != want.kind) report("kind", got.kind, want.kind);
      for (int k = 0; k < 3; k++) begin
        if (got.accel[k] != want.accel[k]) report("accel", got.accel[k], want.accel[k]);
        if (got.rate[k] != want.rate[k]) report("rate", got.rate[k], want.rate[k]);
      end
      for (int k = 0; k < 4; k++)
        if (got.quat[k] != want.quat[k]) report("quat", got.quat[k], want.quat[k]);
      if (got.sample_number != want.sample_number)
        report("sample_number", got.sample_number, want.sample_number);
    end
  endtask

  always @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) parse_byte(rx_byte_i);
    if (!in_valid_i || !in_stall_o) begin
      if (rst_ni && rx_stream.size() > 0 && $urandom_range(0, 99) >= sender_idle) begin
        in_valid_i <= 1'b1;
        rx_byte_i <= rx_stream.pop_front();
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  always @(posedge clk_i) begin
    if (out_valid_o && !out_stall_i) check_result();
    out_stall_i <= rst_ni && ($urandom_range(0, 99) < receiver_stall);
  end

  task automatic queue_byte(input logic [7:0] b);
    rx_stream.insert(rx_stream.size(), b);
    bytes_queued++;
  endtask

  function automatic logic [15:0] pick_word();
    case ($urandom_range(0, 5))
      0: return 16'h8000;
      1: return 16'h7fff;
      2: return 16'h0000;
      3: return 16'hffff;
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic logic [63:0] pick_body();
    return {pick_word(), pick_word(), pick_word(), pick_word()};
  endfunction

  task automatic queue_frame(input logic [7:0] ftype, input logic [63:0] body, input bit corrupt);
    logic [7:0] sum;
    sum = HDR_BYTE + ftype;
    queue_byte(HDR_BYTE);
    queue_byte(ftype);
    for (int i = 0; i < 8; i++) begin
      queue_byte(body[8 * i +: 8]);
      sum = sum + body[8 * i +: 8];
    end
    if (corrupt) sum = sum + 8'($urandom_range(1, 255));
    queue_byte(sum);
  endtask

  task automatic queue_noise();
    logic [7:0] b;
    repeat ($urandom_range(1, 4)) begin
      b = 8'($urandom);
      if (b == HDR_BYTE) b = ~b;
      queue_byte(b);
    end
  endtask

  task automatic run_phase(input int unsigned idle_pct, input int unsigned stall_pct,
                           input int unsigned n_bytes);
    logic [7:0] order[3];
    logic [7:0] tmp;
    logic [7:0] odd_type;
    int unsigned pick;
    int unsigned j;
    sender_idle = idle_pct;
    receiver_stall = stall_pct;
    bytes_queued = 0;
    while (bytes_queued < n_bytes) begin
      pick = $urandom_range(0, 99);
      if (pick < 65) begin
        order = '{TYPE_ACCEL, TYPE_RATE, TYPE_ANGLE};
        for (int i = 2; i > 0; i--) begin
          j = $urandom_range(0, i);
          tmp = order[i];
          order[i] = order[j];
          order[j] = tmp;
        end
        for (int i = 0; i < 3; i++) queue_frame(order[i], pick_body(), $urandom_range(0, 99) < 8);
        queue_frame(TYPE_QUAT, pick_body(), $urandom_range(0, 99) < 8);
      end else if (pick < 82) begin
        case ($urandom_range(0, 3))
          0: odd_type = TYPE_ACCEL;
          1: odd_type = TYPE_RATE;
          2: odd_type = TYPE_ANGLE;
          default: odd_type = TYPE_QUAT;
        endcase
        queue_frame(odd_type, pick_body(), $urandom_range(0, 99) < 30);
      end else if (pick < 90) begin
        odd_type = 8'($urandom);
        while (is_known(odd_type)) odd_type = 8'($urandom);
        queue_frame(odd_type, pick_body(), $urandom_range(0, 1));
      end else if (pick < 97) begin
        queue_noise();
      end else begin
        // truncated frame: the next frame's bytes fill it up
        queue_byte(HDR_BYTE);
        repeat ($urandom_range(1, 9)) queue_byte(8'($urandom));
      end
    end
  endtask

  task automatic drain();
    while (rx_stream.size() != 0 || in_valid_i || parsed_results.size() != 0)
      @(posedge clk_i);
    repeat (6) @(posedge clk_i);
  endtask

  initial begin
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    queue_byte(8'h00);
    queue_byte(8'hff);
    queue_byte(8'h54);
    queue_frame(TYPE_QUAT, {16'h1234, 16'h8000, 16'h7fff, 16'hffff}, 1'b0);
    queue_frame(TYPE_ACCEL, {16'h0000, 16'h0055, 16'h7fff, 16'h8000}, 1'b0);
    queue_frame(TYPE_RATE, {16'hffff, 16'h8000, 16'h0000, 16'hffff}, 1'b0);
    queue_frame(TYPE_ANGLE, {16'h5555, 16'h5555, 16'h5555, 16'h5555}, 1'b0);
    queue_frame(TYPE_QUAT, {16'h8000, 16'h7fff, 16'h0000, 16'hffff}, 1'b0);
    queue_frame(TYPE_ACCEL, {16'h0001, 16'h0002, 16'h0003, 16'h0004}, 1'b1);
    queue_frame(TYPE_QUAT, {16'h0001, 16'h0002, 16'h0003, 16'h0004}, 1'b1);
    queue_frame(8'h00, {16'hffff, 16'hffff, 16'hffff, 16'hffff}, 1'b1);
    queue_frame(8'hff, {16'h0000, 16'h0000, 16'h0000, 16'h0000}, 1'b0);
    queue_frame(TYPE_QUAT, {16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff}, 1'b0);
    drain();

    run_phase(0, 0, 270);
    drain();
    run_phase(75, 0, 270);
    drain();
    run_phase(0, 75, 270);
    drain();
    run_phase(10, 10, 270);
    drain();

    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("Mismatches found");
    $finish;
  end

endmodule
